>>> rtl/sca_pkg.sv
// Shared types and constants for the segment chunk allocator.
`default_nettype none

package sca_pkg;

  localparam int unsigned SEG_SHIFT = 16;
  localparam logic [15:0] SEG_LIMIT = 16'hFFFF;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_REUSED       = 3'd0,
    ST_NEW          = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_FREED_TOP    = 3'd3,
    ST_FREED_LIST   = 3'd4,
    ST_ALREADY_FREE = 3'd5,
    ST_UNKNOWN      = 3'd6
  } status_t;

  typedef struct packed {
    logic        valid;
    logic        freed;
    logic [15:0] offset;
    logic [15:0] size;
  } chunk_rec_t;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

endpackage

`default_nettype wire

>>> rtl/sca_ifs.sv
// Request and response channel interfaces of the segment chunk allocator.
`default_nettype none

interface sca_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] request_size;
  logic [31:0] chunk_address;

  modport source (output valid, action, request_size, chunk_address, input ready);
  modport sink (input valid, action, request_size, chunk_address, output ready);
endinterface

interface sca_rsp_if;
  logic              valid;
  logic              ready;
  sca_pkg::status_t  status;
  logic [31:0]       user_address;

  modport source (output valid, status, user_address, input ready);
  modport sink (input valid, status, user_address, output ready);
endinterface

`default_nettype wire

>>> rtl/sca_rec_ram.sv
// Chunk record memory with one write port and one registered read port.
`default_nettype none

module sca_rec_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire [IDX_W-1:0]           wr_addr,
  input  sca_pkg::chunk_rec_t       wr_data,
  input  wire                       rd_en,
  input  wire [IDX_W-1:0]           rd_addr,
  output sca_pkg::chunk_rec_t       rd_data
);
  import sca_pkg::*;

  chunk_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/segment_chunk_allocator.sv
// Top level of the segment chunk allocator: control sequencer around the record memory.
// A request is accepted only in the idle state. The sequencer then scans the record memory
// through its single read port, one record per cycle, decides once any earlier response is
// taken, registers the response and returns to idle; no new request is accepted before that.
// Reset: synchronous; afterwards a clearing pass invalidates every record, during which no
// request is accepted. Top offset and selector reset to zero.
`default_nettype none

module segment_chunk_allocator #(
  parameter int unsigned MAX_CHUNKS   = 64,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data,
  sca_req_if.sink     req,
  sca_rsp_if.source   rsp
);
  import sca_pkg::*;

  localparam int unsigned IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHUNKS - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(MAX_CHUNKS);
  localparam logic [17:0] HDR18 = 18'(HEADER_BYTES);
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);

  state_t       state;
  logic [15:0]  seg_sel;
  logic [15:0]  top;
  logic [CNT_W-1:0] cnt;

  logic         req_action;
  logic [15:0]  req_size;
  logic [31:0]  tgt;

  logic         ev_vld;
  logic [IDX_W-1:0] ev_idx;

  logic         pick_found;
  logic [IDX_W-1:0] pick_idx;
  logic         pick_freed;
  logic [15:0]  pick_off;
  logic [15:0]  pick_size;
  logic         slot_found;
  logic [IDX_W-1:0] slot_idx;

  logic         out_valid;
  status_t      out_status;
  logic [31:0]  out_addr;

  logic         ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  chunk_rec_t   ram_wr_data;
  logic         ram_rd_en;
  chunk_rec_t   rec;

  logic         accept;
  logic         fire;
  logic         take_pick;
  logic         take_slot;

  logic         dec_wr;
  logic [IDX_W-1:0] dec_addr;
  chunk_rec_t   dec_rec;
  status_t      dec_status;
  logic [31:0]  dec_addr_out;
  logic [15:0]  top_next;
  logic [17:0]  need;
  logic [17:0]  chunk_end;

  function automatic logic [31:0] user_addr(input logic [15:0] sel, input logic [15:0] off);
    return {sel, 16'h0000} + {16'h0000, off} + HDR32;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign fire      = (state == S_DECIDE) && (!out_valid || rsp.ready);
  assign ram_rd_en = (state == S_SCAN) && (cnt < CNT_END);

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.user_address = out_addr;

  sca_rec_ram #(
    .DEPTH (MAX_CHUNKS),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (rec)
  );

  always_comb begin
    take_pick = 1'b0;
    take_slot = 1'b0;
    if (ev_vld) begin
      if (req_action == ACT_ALLOC) begin
        take_pick = rec.valid && rec.freed && (rec.size == req_size) &&
                    (!pick_found || (rec.offset < pick_off));
        take_slot = !rec.valid && !slot_found;
      end else begin
        take_pick = !pick_found && rec.valid && (tgt[31:16] == 16'h0000) &&
                    (rec.offset == tgt[15:0]);
      end
    end
  end

  always_comb begin
    need         = {2'b00, top} + HDR18 + {2'b00, req_size};
    chunk_end    = {2'b00, pick_off} + HDR18 + {2'b00, pick_size};
    dec_wr       = 1'b0;
    dec_addr     = pick_idx;
    dec_rec      = '0;
    dec_status   = ST_NO_SPACE;
    dec_addr_out = 32'h0000_0000;
    top_next     = top;
    if (req_action == ACT_ALLOC) begin
      priority if (pick_found) begin
        dec_wr       = 1'b1;
        dec_rec      = '{valid: 1'b1, freed: 1'b0, offset: pick_off, size: pick_size};
        dec_status   = ST_REUSED;
        dec_addr_out = user_addr(seg_sel, pick_off);
      end else if ((need > {2'b00, SEG_LIMIT}) || !slot_found) begin
        dec_status   = ST_NO_SPACE;
      end else begin
        dec_wr       = 1'b1;
        dec_addr     = slot_idx;
        dec_rec      = '{valid: 1'b1, freed: 1'b0, offset: top, size: req_size};
        dec_status   = ST_NEW;
        dec_addr_out = user_addr(seg_sel, top);
        top_next     = need[15:0];
      end
    end else begin
      priority if (!pick_found) begin
        dec_status = ST_UNKNOWN;
      end else if (pick_freed) begin
        dec_status = ST_ALREADY_FREE;
      end else if (chunk_end == {2'b00, top}) begin
        dec_wr     = 1'b1;
        dec_rec    = '0;
        dec_status = ST_FREED_TOP;
        top_next   = pick_off;
      end else begin
        dec_wr     = 1'b1;
        dec_rec    = '{valid: 1'b1, freed: 1'b1, offset: pick_off, size: pick_size};
        dec_status = ST_FREED_LIST;
      end
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = cnt[IDX_W-1:0];
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = fire && dec_wr;
      ram_wr_addr = dec_addr;
      ram_wr_data = dec_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_sel <= 16'h0000;
    end else if (cfg_wr_en) begin
      seg_sel <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      top        <= 16'h0000;
      ev_vld     <= 1'b0;
      pick_found <= 1'b0;
      slot_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt[IDX_W-1:0] == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_action <= req.action;
            req_size   <= req.request_size;
            tgt        <= req.chunk_address - {seg_sel, 16'h0000} - HDR32;
            cnt        <= '0;
            ev_vld     <= 1'b0;
            pick_found <= 1'b0;
            slot_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          ev_vld <= ram_rd_en;
          ev_idx <= cnt[IDX_W-1:0];
          if (ram_rd_en) begin
            cnt <= cnt + 1'b1;
          end
          if (take_pick) begin
            pick_found <= 1'b1;
            pick_idx   <= ev_idx;
            pick_freed <= rec.freed;
            pick_off   <= rec.offset;
            pick_size  <= rec.size;
          end
          if (take_slot) begin
            slot_found <= 1'b1;
            slot_idx   <= ev_idx;
          end
          if (ev_vld && (ev_idx == LAST_IDX)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (fire) begin
            top        <= top_next;
            out_valid  <= 1'b1;
            out_status <= dec_status;
            out_addr   <= dec_addr_out;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/sca_scoreboard_pkg.sv
// Response predictor and scoreboard for the segment chunk allocator testbench.
`timescale 1ns / 100ps

package sca_scoreboard_pkg;

  import sca_pkg::*;

  localparam int unsigned MAX_CHUNKS   = 64;
  localparam int unsigned HEADER_BYTES = 12;

  typedef struct {
    status_t     status;
    logic [31:0] user_address;
  } chunk_response_t;

  class chunk_scoreboard;
    chunk_rec_t      records [MAX_CHUNKS];
    logic [15:0]     selector;
    logic [15:0]     top;
    chunk_response_t awaited_responses [$];
    int              errors;
    int              responses;
    int              status_seen [7];
    int              limit_refusals;
    int              full_refusals;

    function new();
      selector       = '0;
      top            = '0;
      errors         = 0;
      responses      = 0;
      limit_refusals = 0;
      full_refusals  = 0;
      foreach (records[i]) records[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function logic [31:0] user_addr(logic [15:0] offset);
      return {selector, 16'h0000} + {16'h0000, offset} + HEADER_BYTES;
    endfunction

    function void set_selector(logic [15:0] value);
      selector = value;
    endfunction

    function int pending();
      return awaited_responses.size();
    endfunction

    // Notes an accepted request, updates the predicted state and returns the
    // user address that the response should carry.
    function logic [31:0] apply_request(logic act, logic [15:0] size, logic [31:0] addr);
      chunk_response_t rsp;
      int              best;
      int              slot;
      int              hit;
      logic [31:0]     need;
      logic [31:0]     chunk_end;
      best = -1;
      slot = -1;
      hit  = -1;
      rsp.status       = ST_NO_SPACE;
      rsp.user_address = '0;
      if (act == ACT_ALLOC) begin
        for (int i = 0; i < MAX_CHUNKS; i++) begin
          if (records[i].valid) begin
            if (records[i].freed && records[i].size == size &&
                (best < 0 || records[i].offset < records[best].offset)) begin
              best = i;
            end
          end else if (slot < 0) begin
            slot = i;
          end
        end
        need = {16'h0000, top} + HEADER_BYTES + {16'h0000, size};
        if (best >= 0) begin
          records[best].freed = 1'b0;
          rsp.status       = ST_REUSED;
          rsp.user_address = user_addr(records[best].offset);
        end else if (need > {16'h0000, SEG_LIMIT}) begin
          limit_refusals++;
        end else if (slot < 0) begin
          full_refusals++;
        end else begin
          records[slot].valid  = 1'b1;
          records[slot].freed  = 1'b0;
          records[slot].offset = top;
          records[slot].size   = size;
          rsp.status       = ST_NEW;
          rsp.user_address = user_addr(top);
          top = need[15:0];
        end
      end else begin
        for (int i = 0; i < MAX_CHUNKS; i++) begin
          if (hit < 0 && records[i].valid && user_addr(records[i].offset) == addr) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          rsp.status = ST_UNKNOWN;
        end else if (records[hit].freed) begin
          rsp.status = ST_ALREADY_FREE;
        end else begin
          chunk_end = {16'h0000, records[hit].offset} + HEADER_BYTES +
                      {16'h0000, records[hit].size};
          if (chunk_end == {16'h0000, top}) begin
            top = records[hit].offset;
            records[hit].valid = 1'b0;
            records[hit].freed = 1'b0;
            rsp.status = ST_FREED_TOP;
          end else begin
            records[hit].freed = 1'b1;
            rsp.status = ST_FREED_LIST;
          end
        end
      end
      awaited_responses.push_back(rsp);
      return rsp.user_address;
    endfunction

    // Picks the user address of a chunk that the allocator currently holds, or a random address if it holds none.
    function logic [31:0] known_address();
      int held [$];
      foreach (records[i]) begin
        if (records[i].valid) held.push_back(i);
      end
      if (held.size() == 0) return $urandom();
      return user_addr(records[held[$urandom_range(0, held.size() - 1)]].offset);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(status_t status, logic [31:0] user_address);
      chunk_response_t exp;
      if (awaited_responses.size() == 0) begin
        report($sformatf("response status %0d address %h with no request outstanding",
                         status, user_address));
        return;
      end
      exp = awaited_responses.pop_front();
      responses++;
      status_seen[int'(exp.status)]++;
      if (status !== exp.status) begin
        report($sformatf("status %0d, expected %0d", status, exp.status));
      end
      if (user_address !== exp.user_address) begin
        report($sformatf("user address %h, expected %h", user_address, exp.user_address));
      end
    endtask
  endclass

endpackage

>>> tb/segment_chunk_allocator_test.sv
// Top level testbench of the segment chunk allocator: stimulus, handshakes and final verdict.
`timescale 1ns / 100ps

module segment_chunk_allocator_test;

  import sca_pkg::*;
  import sca_scoreboard_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int requests_sent      = 0;
  int selector_writes    = 0;

  chunk_scoreboard sb = new();

  sca_req_if req_ch ();
  sca_rsp_if rsp_ch ();

  segment_chunk_allocator #(
    .MAX_CHUNKS  (MAX_CHUNKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        sb.check_result(rsp_ch.status, rsp_ch.user_address);
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  task automatic send_request(input logic act, input logic [15:0] size,
                              input logic [31:0] addr, output logic [31:0] expected_addr);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= act;
    req_ch.request_size  <= size;
    req_ch.chunk_address <= addr;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_addr = sb.apply_request(act, size, addr);
    requests_sent++;
  endtask

  task automatic alloc(input logic [15:0] size, output logic [31:0] user_address);
    send_request(ACT_ALLOC, size, $urandom(), user_address);
  endtask

  task automatic free_chunk(input logic [31:0] addr);
    logic [31:0] unused;
    send_request(ACT_FREE, 16'($urandom()), addr, unused);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_selector(input logic [15:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_selector(value);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 16'($urandom());
    selector_writes++;
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      case ($urandom_range(0, 7))
        0:       return 16'd0;
        1:       return 16'd1;
        2:       return 16'd4;
        3:       return 16'd12;
        4:       return 16'd16;
        5:       return 16'd40;
        6:       return 16'd100;
        default: return 16'd256;
      endcase
    end
    if (r < 80) return 16'($urandom_range(0, 600));
    if (r < 95) return 16'($urandom_range(0, 8000));
    return 16'($urandom());
  endfunction

  task automatic random_request(input int alloc_pct);
    int          r;
    logic [31:0] ua;
    logic [31:0] addr;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      alloc(pick_size(), ua);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        addr = sb.known_address();
      end else if (r < 90) begin
        addr = sb.known_address() ^ (32'h1 << $urandom_range(0, 31));
      end else begin
        addr = $urandom();
      end
      free_chunk(addr);
    end
  endtask

  initial begin
    logic [31:0] a_addr;
    logic [31:0] b_addr;
    logic [31:0] c_addr;
    logic [31:0] d_addr;
    logic [31:0] e_addr;
    logic [31:0] scratch;
    logic [15:0] sel;
    int          alloc_pct;

    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.action        <= ACT_ALLOC;
    req_ch.request_size  <= '0;
    req_ch.chunk_address <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_selector(16'hFFFF);
    alloc(16'd0, scratch);
    alloc(16'hFFFF, scratch);
    alloc(16'd100, a_addr);
    alloc(16'd50, b_addr);
    alloc(16'd100, c_addr);
    alloc(16'd8, d_addr);
    free_chunk(c_addr);
    free_chunk(a_addr);
    free_chunk(a_addr);
    alloc(16'd100, scratch);
    alloc(16'd100, scratch);
    free_chunk(d_addr);
    free_chunk(c_addr);
    free_chunk(32'hFFFF_FFFF);
    free_chunk(32'h0000_0000);
    free_chunk(a_addr + 32'd1);
    free_chunk(b_addr);
    alloc(16'(32'(SEG_LIMIT) - 32'(sb.top) - HEADER_BYTES), e_addr);
    alloc(16'd0, scratch);
    free_chunk(e_addr);
    free_chunk(e_addr);
    alloc(16'(32'(SEG_LIMIT) - 32'(sb.top) - HEADER_BYTES + 1), scratch);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       sel = 16'h0000;
        1:       sel = 16'h8000;
        3:       sel = 16'hFFFF;
        4:       sel = 16'h0001;
        6:       sel = 16'h7FFF;
        7:       sel = 16'h0000;
        default: sel = 16'($urandom());
      endcase
      write_selector(sel);
      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 73;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 73;
        end
        default: begin
          sender_idle_pct    = 14;
          receiver_stall_pct = 14;
        end
      endcase
      alloc_pct = (phase < 4) ? 60 : ((phase % 2 == 1) ? 80 : 40);
      for (int n = 0; n < 190; n++) begin
        random_request(alloc_pct);
        if ($urandom_range(0, 59) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (MAX_CHUNKS + 8) @(posedge clk);
    $display("covered %0d requests under %0d selector settings, %0d refused at the limit",
             requests_sent, selector_writes, sb.limit_refusals);
    $display("full table %0d; reused %0d, new %0d, no space %0d, top %0d, list %0d, %0d, %0d",
             sb.full_refusals, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4], sb.status_seen[5], sb.status_seen[6]);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
